// ===== hw/rtl/mulaw_decode_upsample_2x_assert.svh =====
// Assertion macros for the mu-law decoder with 2x upsampling.
`ifndef MULAW_DECODE_UPSAMPLE_2X_ASSERT_SVH
`define MULAW_DECODE_UPSAMPLE_2X_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/mdu2x_pkg.sv =====
// Package with sample types, result positions and mu-law decode functions.
`timescale 1ns / 1ps

package mdu2x_pkg;

    localparam int SAMPLE_W = 14;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [1:0]                 pos_t;

    // Position of a result within the four-result sequence of a buffer's last byte.
    localparam pos_t POS_HELD = 2'd0;
    localparam pos_t POS_MID  = 2'd1;
    localparam pos_t POS_CUR  = 2'd2;
    localparam pos_t POS_END  = 2'd3;

    localparam logic [5:0] MULAW_BIAS = 6'd33;

    // G.711 mu-law expansion to linear PCM in -8031..8031.
    function automatic sample_t expand_mulaw(input logic [7:0] code);
        logic [7:0]  inv;
        logic [5:0]  base;
        logic [12:0] mag;
        sample_t     magx;
        sample_t     bias;
        begin
            inv  = ~code;
            base = {1'b0, inv[3:0], 1'b0} + MULAW_BIAS;
            mag  = 13'(base) << inv[6:4];
            magx = sample_t'({1'b0, mag});
            bias = sample_t'({8'd0, MULAW_BIAS});
            expand_mulaw = inv[7] ? (bias - magx) : (magx - bias);
        end
    endfunction

    // Midpoint of two samples, the halved sum truncated toward zero.
    function automatic sample_t midpoint(input sample_t a, input sample_t b);
        logic signed [SAMPLE_W:0] sum;
        logic signed [SAMPLE_W:0] adj;
        logic signed [SAMPLE_W:0] half;
        begin
            sum  = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
            adj  = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
            half = adj >>> 1;
            midpoint = half[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/mulaw_decode_upsample_2x.sv =====
// Top level: mu-law decoder with 2x linear upsampling and a buffer-end mark.
`timescale 1ns / 1ps

//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------
//  input   | in_valid, in_ready  | mulaw_byte, block_last
//  output  | out_valid, out_ready| pcm_sample, run_end, buffer_end
//
// The output register sends one result per cycle while out_ready is high, and that
// register sets the rate. A byte in the middle of a buffer gives two results; the first
// byte of a longer buffer gives none and the last byte of a buffer gives up to four.
// Back-to-back bytes after a buffer's first byte keep the output busy at that rate.
// Reset clears the held sample, the stage valid bits and the result counter.
// A stall on the output holds the result register and then the input stage.

module mulaw_decode_upsample_2x
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             mulaw_byte,
    input  logic                   block_last,

    output logic                   out_valid,
    input  logic                   out_ready,
    output mdu2x_pkg::sample_t     pcm_sample,
    output logic                   run_end,
    output logic                   buffer_end
);

`include "mulaw_decode_upsample_2x_assert.svh"

    // Input stage: one accepted transaction waits here until its results are sent.
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                s1_last_reg;

    // Index of the next result of the current item.
    logic [1:0]          idx_reg;

    // The previous decoded sample of the buffer and whether one is held.
    mdu2x_pkg::sample_t  held_sample_reg;
    logic                held_valid_reg;

    // Result register.
    logic                out_valid_reg;
    mdu2x_pkg::sample_t  out_sample_reg;
    logic                out_run_end_reg;
    logic                out_buffer_end_reg;

    mdu2x_pkg::sample_t  cur_sample;
    mdu2x_pkg::sample_t  mid_sample;
    mdu2x_pkg::pos_t     pos;
    mdu2x_pkg::sample_t  res_sample;
    logic                res_run_end;
    logic                res_buffer_end;
    logic                has_results;
    logic                out_free;
    logic                emit;
    logic                retire;

    assign cur_sample = mdu2x_pkg::expand_mulaw(s1_byte_reg);
    assign mid_sample = mdu2x_pkg::midpoint(held_sample_reg, cur_sample);

    // The first byte of a buffer that is not also its last byte is only stored.
    assign has_results = held_valid_reg || s1_last_reg;

    // Without a held sample only the two copies of the current sample are sent,
    // so the sequence starts at the third position.
    assign pos = held_valid_reg ? idx_reg : {1'b1, idx_reg[0]};

    always_comb
    begin
        case (pos)
            mdu2x_pkg::POS_HELD:
            begin
                res_sample     = held_sample_reg;
                res_run_end    = 1'b0;
                res_buffer_end = 1'b0;
            end
            mdu2x_pkg::POS_MID:
            begin
                res_sample     = mid_sample;
                res_run_end    = !s1_last_reg;
                res_buffer_end = 1'b0;
            end
            mdu2x_pkg::POS_CUR:
            begin
                res_sample     = cur_sample;
                res_run_end    = 1'b0;
                res_buffer_end = 1'b0;
            end
            default:
            begin
                res_sample     = cur_sample;
                res_run_end    = 1'b1;
                res_buffer_end = 1'b1;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = s1_valid_reg && has_results && out_free;

    // The item leaves the input stage with its final result, or at once if it has none.
    assign retire   = s1_valid_reg && (!has_results || (emit && res_run_end));
    assign in_ready = !s1_valid_reg || retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            idx_reg         <= 2'd0;
            held_valid_reg  <= 1'b0;
            held_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end

            if (retire)
            begin
                idx_reg <= 2'd0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (retire)
            begin
                held_sample_reg <= cur_sample;
                held_valid_reg  <= !s1_last_reg;
            end

            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= mulaw_byte;
            s1_last_reg <= block_last;
        end

        if (emit)
        begin
            out_sample_reg     <= res_sample;
            out_run_end_reg    <= res_run_end;
            out_buffer_end_reg <= res_buffer_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pcm_sample = out_sample_reg;
    assign run_end    = out_run_end_reg;
    assign buffer_end = out_buffer_end_reg;

    // Assertions.
    `ASSERT_NEXT(a_last_clears_held, clk, rst_n, retire && s1_last_reg, !held_valid_reg, "held sample survived the end of a buffer")
    `ASSERT_NEXT(a_inner_keeps_held, clk, rst_n, retire && !s1_last_reg, held_valid_reg, "held sample lost inside a buffer")
    `ASSERT_IMPLY(a_short_sequence, clk, rst_n, s1_valid_reg && !held_valid_reg, !idx_reg[1], "result index overran a two-result sequence")
    `ASSERT_IMPLY(a_end_marks, clk, rst_n, out_valid_reg && out_buffer_end_reg, out_run_end_reg, "buffer end without run end")

endmodule
